### design/stream_byte_reassembler_assert.svh
// Assertion macros for the stream byte reassembler checker.
// Included by the checker file only; depends on nothing else.
`ifndef STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_ASSERT_SVH

// Checks cons in the same cycle as ante, outside of reset.
`define SRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stream_byte_reassembler check failed");

// Checks cons in the cycle after ante, outside of reset.
`define SRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stream_byte_reassembler check failed");

`endif

### design/srb_pkg.sv
// Package of the stream byte reassembler: default sizes and the controller states.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

   localparam int CAPACITY_DEFAULT   = 4096;
   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int BYTE_W             = 8;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_REPLY
   } srb_state_type;

endpackage

`default_nettype wire

### design/stream_byte_reassembler.sv
// Top level of the stream byte reassembler: ring store, window checks and controller.
// Depends on srb_pkg for default sizes and the state type.
// The block holds the bytes of a reordered stream in a ring memory of CAPACITY slots, each
// slot one data byte and a present bit, and hands them out in stream order on drain ticks.
// After reset the block sweeps the memory to clear the present bits, one slot per cycle, and
// it accepts its first transfer only when the sweep is done. Each transfer then passes the
// synchronous memory read, then the read-modify-write and the result register; when results
// are taken at once, the hand-over of a result overlaps the acceptance of the next transfer.
// Every transfer gives exactly one result transfer.
`timescale 1ns / 1ps
`default_nettype none

module stream_byte_reassembler #(
   parameter  int CAPACITY   = srb_pkg::CAPACITY_DEFAULT,
   parameter  int INDEX_BITS = srb_pkg::INDEX_BITS_DEFAULT,
   localparam int REQ_DATA_W = ((INDEX_BITS + srb_pkg::BYTE_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((srb_pkg::BYTE_W + 1 + $clog2(CAPACITY + 1) + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata fields from bit 0: byte_index, byte_value, zero fill.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   // req_tuser fields from bit 0: mode, has_byte, seg_eof.
   input  wire logic [2:0]            req_tuser,
   // rsp_tdata fields from bit 0: out_byte, stream_end, unassembled_count, zero fill.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser fields from bit 0: out_valid.
   output logic                       rsp_tuser
);

   localparam int BYTE_W     = srb_pkg::BYTE_W;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int WORD_W     = BYTE_W + 1;

   localparam logic [INDEX_BITS:0] CAP_DIST = (INDEX_BITS + 1)'(CAPACITY);
   localparam logic [SLOT_W:0]     CAP_SUM  = (SLOT_W + 1)'(CAPACITY);
   localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(CAPACITY - 1);

   srb_pkg::srb_state_type state_ff, state_in;

   logic [WORD_W-1:0] ring_ff [CAPACITY];
   logic [WORD_W-1:0] rd_word_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_word;

   logic [SLOT_W-1:0]     clear_idx_ff, clear_idx_in;
   logic [INDEX_BITS-1:0] next_exp_ff, next_exp_in;
   logic [SLOT_W-1:0]     head_slot_ff, head_slot_in;
   logic                  eof_known_ff, eof_known_in;
   logic [INDEX_BITS-1:0] eof_pos_ff, eof_pos_in;
   logic [COUNT_W-1:0]    pending_ff, pending_in;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                  out_valid_ff, out_valid_in;

   logic                  mode_ff, has_byte_ff, seg_last_ff, seg_eof_ff;
   logic [INDEX_BITS-1:0] pos_ff;
   logic [BYTE_W-1:0]     val_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   logic                  accept;
   logic                  clear_done;
   logic [INDEX_BITS-1:0] req_pos;
   logic [INDEX_BITS-1:0] req_dist;
   logic [SLOT_W:0]       slot_sum;

   logic                  present;
   logic [BYTE_W-1:0]     stored;
   logic [INDEX_BITS-1:0] byte_dist, eof_dist, epos, epos_dist;
   logic                  store_ok, eof_set, done, deliver;

   assign req_pos    = req_tdata[INDEX_BITS-1:0];
   assign accept     = req_tvalid && req_tready;
   assign clear_done = (clear_idx_ff == LAST_SLOT);

   // Slot of an arriving byte, counted from the head slot; valid whenever it lies in the window.
   always_comb begin
      req_dist = req_pos - next_exp_ff;
      slot_sum = {1'b0, head_slot_ff} + {1'b0, req_dist[SLOT_W-1:0]};
      if (slot_sum >= CAP_SUM) begin
         slot_sum = slot_sum - CAP_SUM;
      end
      slot_in = req_tuser[0] ? head_slot_ff : slot_sum[SLOT_W-1:0];
      rd_addr = slot_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srb_pkg::ST_CLEAR: begin
            if (clear_done) begin
               state_in = srb_pkg::ST_IDLE;
            end
         end
         srb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = srb_pkg::ST_LOOKUP;
            end
         end
         srb_pkg::ST_LOOKUP: begin
            state_in = srb_pkg::ST_REPLY;
         end
         srb_pkg::ST_REPLY: begin
            if (accept) begin
               state_in = srb_pkg::ST_LOOKUP;
            end else if (rsp_tready) begin
               state_in = srb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srb_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         srb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         srb_pkg::ST_REPLY: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      present   = rd_word_ff[BYTE_W];
      stored    = rd_word_ff[BYTE_W-1:0];
      byte_dist = pos_ff - next_exp_ff;
      eof_dist  = eof_pos_ff - next_exp_ff;
      epos      = pos_ff + INDEX_BITS'(has_byte_ff);
      epos_dist = epos - next_exp_ff;
      done      = eof_known_ff && (next_exp_ff == eof_pos_ff);

      store_ok = !mode_ff && has_byte_ff && ({1'b0, byte_dist} < CAP_DIST)
                 && (!eof_known_ff || (byte_dist < eof_dist));
      eof_set  = !mode_ff && seg_eof_ff && (seg_last_ff || !has_byte_ff) && !eof_known_ff
                 && ({1'b0, epos_dist} <= CAP_DIST);
      deliver  = mode_ff && !done && present;

      next_exp_in  = next_exp_ff;
      head_slot_in = head_slot_ff;
      eof_known_in = eof_known_ff;
      eof_pos_in   = eof_pos_ff;
      pending_in   = pending_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      clear_idx_in = clear_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_word      = {1'b0, stored};

      if (state_ff == srb_pkg::ST_CLEAR) begin
         wr_en        = 1'b1;
         wr_addr      = clear_idx_ff;
         wr_word      = '0;
         clear_idx_in = clear_idx_ff + 1'b1;
      end else if (state_ff == srb_pkg::ST_LOOKUP) begin
         out_valid_in = deliver;
         out_byte_in  = deliver ? stored : '0;
         if (store_ok) begin
            wr_en   = 1'b1;
            wr_word = {1'b1, val_ff};
            if (!present) begin
               pending_in = pending_ff + 1'b1;
            end
         end
         if (eof_set) begin
            eof_known_in = 1'b1;
            eof_pos_in   = epos;
         end
         if (deliver) begin
            wr_en       = 1'b1;
            wr_word     = {1'b0, stored};
            next_exp_in = next_exp_ff + 1'b1;
            head_slot_in = (head_slot_ff == LAST_SLOT) ? '0 : head_slot_ff + 1'b1;
            if (pending_ff != '0) begin
               pending_in = pending_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srb_pkg::ST_CLEAR;
         clear_idx_ff <= '0;
         next_exp_ff  <= '0;
         head_slot_ff <= '0;
         eof_known_ff <= 1'b0;
         eof_pos_ff   <= '0;
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         next_exp_ff  <= next_exp_in;
         head_slot_ff <= head_slot_in;
         eof_known_ff <= eof_known_in;
         eof_pos_ff   <= eof_pos_in;
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      if (accept) begin
         mode_ff     <= req_tuser[0];
         has_byte_ff <= req_tuser[1];
         seg_eof_ff  <= req_tuser[2];
         seg_last_ff <= req_tlast;
         pos_ff      <= req_pos;
         val_ff      <= req_tdata[INDEX_BITS +: BYTE_W];
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= ring_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_word;
      end
   end

   assign rsp_tuser = out_valid_ff;
   assign rsp_tdata = RSP_DATA_W'({pending_ff,
                                   eof_known_ff && (next_exp_ff == eof_pos_ff),
                                   out_byte_ff});

endmodule

`default_nettype wire

### design/srb_checker.sv
// Port checker of the stream byte reassembler and its bind to the top level.
// Depends on srb_pkg and on the macros in stream_byte_reassembler_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stream_byte_reassembler_assert.svh"

module srb_checker #(
   parameter  int CAPACITY   = srb_pkg::CAPACITY_DEFAULT,
   parameter  int INDEX_BITS = srb_pkg::INDEX_BITS_DEFAULT,
   localparam int REQ_DATA_W = ((INDEX_BITS + srb_pkg::BYTE_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((srb_pkg::BYTE_W + 1 + $clog2(CAPACITY + 1) + 7) / 8) * 8
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  req_tlast,
   input wire logic [2:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   localparam int BYTE_W     = srb_pkg::BYTE_W;

   logic req_xfer;
   logic unused_ok;

   assign req_xfer  = req_tvalid && req_tready;
   assign unused_ok = ^{req_tdata, req_tlast, req_tuser};

   // A held result keeps its contents until the transfer completes.
   `SRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // Every result follows the transfer that caused it, with the lookup state in between.
   `SRB_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
                   $past(req_xfer, 2))
   // One item is in work at a time, so no transfer directly follows another.
   `SRB_ASSERT_NEXT(a_req_spacing, clock, reset, req_xfer, !req_tready)
   // A result without a delivered byte carries a zero byte.
   `SRB_ASSERT_NOW(a_empty_byte, clock, reset, rsp_tvalid && !rsp_tuser && !unused_ok,
                   rsp_tdata[BYTE_W-1:0] == '0)
   `SRB_ASSERT_NOW(a_empty_byte_b, clock, reset, rsp_tvalid && !rsp_tuser && unused_ok,
                   rsp_tdata[BYTE_W-1:0] == '0)

endmodule

bind stream_byte_reassembler srb_checker #(
   .CAPACITY   (CAPACITY),
   .INDEX_BITS (INDEX_BITS)
) u_srb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
